### src/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge out of reset
`define LPHS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen out of reset
`define LPHS_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### src/lphs_pkg.sv
`timescale 1ns / 1ps
package lphs_pkg;

	// table size is a power of two, so the home slot is the low key bits
	localparam int TABLE_ENTRIES = 4096;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	localparam int KEY_W = 32;
	localparam int ACT_W = 2;
	localparam int STAT_W = 3;
	localparam int SLOT_W = 12;

	typedef logic [KEY_W-1:0] key_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [ACT_W-1:0] act_t;
	typedef logic [STAT_W-1:0] stat_t;
	typedef logic [SLOT_W-1:0] slot_t;

	localparam act_t ACT_LOOKUP = 2'd0;
	localparam act_t ACT_INSERT = 2'd1;
	localparam act_t ACT_BULK = 2'd2;
	localparam act_t ACT_RSVD = 2'd3;

	localparam stat_t ST_ABSENT = 3'd0;
	localparam stat_t ST_PRESENT = 3'd1;
	localparam stat_t ST_INSERTED = 3'd2;
	localparam stat_t ST_FULL = 3'd3;
	localparam stat_t ST_BADKEY = 3'd4;

endpackage

### src/lphs_ram.sv
`timescale 1ns / 1ps
module lphs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/linear_probe_hash_set.sv
`timescale 1ns / 1ps
// a zero key, or a bulk load while every slot is taken, answers in the cycle after the
// start beat; otherwise the walk probes one slot per cycle from the home slot on, through
// the single read port of the key table, until it meets an empty slot, the key (not on a
// bulk load) or every slot. a new start is taken in the cycle the last result shows.
// reset: every slot of the key table is cleared, one slot per cycle, with busy high.
// results show on status and slot for one cycle with done high; they cannot be held off.
`include "assert_macros.svh"
module linear_probe_hash_set
	import lphs_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  act_t  action,
	input  key_t  key,
	output logic  busy,
	output logic  done,
	output stat_t status,
	output slot_t slot
);

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE = 2'd1;
	localparam logic [1:0] S_PROBE = 2'd2;

	logic [1:0] state_q;
	idx_t clr_q;
	idx_t addr_q;
	idx_t probe_q;
	act_t action_q;
	key_t key_q;
	cnt_t occ_q;
	logic done_q;
	stat_t status_q;
	slot_t slot_q;

	logic rd_en;
	idx_t rd_addr;
	key_t rd_data;
	logic wr_en;
	idx_t wr_addr;
	key_t wr_data;

	logic accept;
	logic hit_empty;
	logic hit_key;
	logic last_probe;
	logic is_insert;
	logic match_key;

	assign accept = (state_q == S_IDLE) && start;
	assign busy = (state_q != S_IDLE);

	assign match_key = (action_q != ACT_BULK);
	assign is_insert = (action_q == ACT_INSERT) || (action_q == ACT_BULK);
	assign hit_empty = (rd_data == '0);
	assign hit_key = match_key && (rd_data == key_q);
	assign last_probe = (probe_q == IDX_W'(TABLE_ENTRIES - 1));

	always_comb begin
		rd_en = 1'b0;
		rd_addr = addr_q + idx_t'(1);
		wr_en = 1'b0;
		wr_addr = addr_q;
		wr_data = key_q;
		case (state_q)
			S_CLEAR: begin
				wr_en = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
			end
			S_IDLE: begin
				rd_en = accept;
				rd_addr = key[IDX_W-1:0];
			end
			S_PROBE: begin
				if (hit_empty) begin
					wr_en = is_insert;
				end else if (!hit_key && !last_probe) begin
					rd_en = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	lphs_ram #(
		.WIDTH(KEY_W),
		.DEPTH(TABLE_ENTRIES)
	) u_key_table (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			occ_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + idx_t'(1);
					if (clr_q == IDX_W'(TABLE_ENTRIES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (key == '0) begin
							done_q <= 1'b1;
						end else if (action == ACT_BULK && occ_q == CNT_W'(TABLE_ENTRIES)) begin
							// no empty slot anywhere, a bulk load cannot land
							done_q <= 1'b1;
						end else begin
							state_q <= S_PROBE;
						end
					end
				end
				S_PROBE: begin
					if (hit_empty || hit_key || last_probe) begin
						done_q <= 1'b1;
						state_q <= S_IDLE;
						if (hit_empty && is_insert) begin
							occ_q <= occ_q + cnt_t'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload and walk position
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					action_q <= action;
					key_q <= key;
					addr_q <= key[IDX_W-1:0];
					probe_q <= '0;
					slot_q <= '0;
					if (key == '0) begin
						status_q <= ST_BADKEY;
					end else begin
						status_q <= ST_FULL;
					end
				end
			end
			S_PROBE: begin
				if (hit_empty) begin
					if (is_insert) begin
						status_q <= ST_INSERTED;
						slot_q <= SLOT_W'(addr_q);
					end else begin
						status_q <= ST_ABSENT;
						slot_q <= '0;
					end
				end else if (hit_key) begin
					status_q <= ST_PRESENT;
					slot_q <= SLOT_W'(addr_q);
				end else if (last_probe) begin
					status_q <= ST_FULL;
					slot_q <= '0;
				end else begin
					addr_q <= addr_q + idx_t'(1);
					probe_q <= probe_q + idx_t'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign status = status_q;
	assign slot = slot_q;

	`LPHS_ASSERT(a_done_idle, clk, arst_n, done |-> !busy, "result beat while busy")
	`LPHS_ASSERT(a_start_moves, clk, arst_n, (start && !busy) |=> (busy || done),
		"accepted beat neither probing nor answered")
	`LPHS_NEVER(a_occ_range, clk, arst_n, occ_q > CNT_W'(TABLE_ENTRIES),
		"occupied count beyond table size")
	`LPHS_ASSERT(a_insert_count, clk, arst_n,
		(done && status == ST_INSERTED) |-> (occ_q == $past(occ_q) + cnt_t'(1)),
		"insert without count step")
	`LPHS_ASSERT(a_slot_zero, clk, arst_n,
		(done && (status == ST_ABSENT || status == ST_FULL || status == ST_BADKEY))
		|-> (slot == '0), "nonzero slot on a miss")

endmodule
